@@ src/threefish512_block_cipher_top_macros.svh @@
// Assertion macros for the Threefish-512 block cipher
`ifndef THREEFISH512_BLOCK_CIPHER_TOP_MACROS_SVH
`define THREEFISH512_BLOCK_CIPHER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TF_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TF_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define TF_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TF_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ src/tf512_pkg.sv @@
// Types, constants and round functions for the Threefish-512 block cipher
`default_nettype none
package tf512_pkg;
    localparam logic [63:0] KEY_PARITY = 64'h1bd11bdaa9fc1a22;
    localparam int WORDS = 8;
    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    typedef logic [63:0] word_t;
    typedef word_t [7:0] block_t;

    typedef struct packed {
        logic   func;
        block_t x;
        word_t  tw0;
        word_t  tw1;
    } item_t;

    function automatic logic [5:0] rot_amt(input logic [2:0] r, input logic [1:0] j);
        logic [5:0] v;
        case ({r, j})
            5'd0: v = 6'd46;  5'd1: v = 6'd36;  5'd2: v = 6'd19;  5'd3: v = 6'd37;
            5'd4: v = 6'd33;  5'd5: v = 6'd27;  5'd6: v = 6'd14;  5'd7: v = 6'd42;
            5'd8: v = 6'd17;  5'd9: v = 6'd49;  5'd10: v = 6'd36; 5'd11: v = 6'd39;
            5'd12: v = 6'd44; 5'd13: v = 6'd9;  5'd14: v = 6'd54; 5'd15: v = 6'd56;
            5'd16: v = 6'd39; 5'd17: v = 6'd30; 5'd18: v = 6'd34; 5'd19: v = 6'd24;
            5'd20: v = 6'd13; 5'd21: v = 6'd50; 5'd22: v = 6'd10; 5'd23: v = 6'd17;
            5'd24: v = 6'd25; 5'd25: v = 6'd29; 5'd26: v = 6'd39; 5'd27: v = 6'd43;
            5'd28: v = 6'd8;  5'd29: v = 6'd35; 5'd30: v = 6'd56; 5'd31: v = 6'd22;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

    function automatic word_t rotl(input word_t v, input logic [5:0] r);
        return (v << r) | (v >> (7'd64 - {1'b0, r}));
    endfunction

    function automatic word_t rotr(input word_t v, input logic [5:0] r);
        return (v >> r) | (v << (7'd64 - {1'b0, r}));
    endfunction

    // Subkey s (an elaboration constant): kw has 9 words, tweak t0, t1.
    function automatic block_t subkey(input int s, input word_t [8:0] kw,
                                      input word_t t0, input word_t t1);
        block_t sk;
        word_t  tw [3];
        tw[0] = t0;
        tw[1] = t1;
        tw[2] = t0 ^ t1;
        for (int i = 0; i < 8; i++)
        begin
            sk[i] = kw[4'((s + i) % 9)];
        end
        sk[5] = sk[5] + tw[2'(s % 3)];
        sk[6] = sk[6] + tw[2'((s + 1) % 3)];
        sk[7] = sk[7] + 64'(s);
        return sk;
    endfunction

    function automatic block_t enc_round(input block_t x, input logic [2:0] r);
        block_t y;
        block_t p;
        for (int j = 0; j < 4; j++)
        begin
            y[2*j] = x[2*j] + x[2*j+1];
            y[2*j+1] = rotl(x[2*j+1], rot_amt(r, 2'(j))) ^ y[2*j];
        end
        p[0] = y[2]; p[1] = y[1]; p[2] = y[4]; p[3] = y[7];
        p[4] = y[6]; p[5] = y[5]; p[6] = y[0]; p[7] = y[3];
        return p;
    endfunction

    function automatic block_t dec_round(input block_t x, input logic [2:0] r);
        block_t p;
        block_t y;
        p[2] = x[0]; p[1] = x[1]; p[4] = x[2]; p[7] = x[3];
        p[6] = x[4]; p[5] = x[5]; p[0] = x[6]; p[3] = x[7];
        for (int j = 0; j < 4; j++)
        begin
            y[2*j+1] = rotr(p[2*j+1] ^ p[2*j], rot_amt(r, 2'(j)));
            y[2*j] = p[2*j] - y[2*j+1];
        end
        return y;
    endfunction

    function automatic block_t add_blk(input block_t a, input block_t b, input logic sub);
        block_t y;
        for (int i = 0; i < 8; i++)
        begin
            y[i] = sub ? a[i] - b[i] : a[i] + b[i];
        end
        return y;
    endfunction
endpackage
`default_nettype wire

@@ src/tf512_stage.sv @@
// One pipeline stage: four rounds with a subkey injection, plus the last subkey in the first or last stage
`default_nettype none
module tf512_stage
    import tf512_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int GROUPS = 18
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire item_t         in_item,
    input  wire logic [575:0]  kw_flat,
    output logic               out_valid,
    output item_t              out_item
);
    item_t       item_reg;
    logic        valid_reg;
    item_t       item_next;
    word_t [8:0] kw;
    block_t      x;
    block_t      sk;

    assign kw = kw_flat;

    always_comb
    begin
        item_next = in_item;
        x = in_item.x;
        if (in_item.func == FUNC_ENCRYPT)
        begin
            sk = subkey(STAGE, kw, in_item.tw0, in_item.tw1);
            x = add_blk(x, sk, 1'b0);
            for (int d = 0; d < 4; d++)
            begin
                x = enc_round(x, 3'((STAGE * 4 + d) % 8));
            end
            if (STAGE == GROUPS - 1)
            begin
                sk = subkey(GROUPS, kw, in_item.tw0, in_item.tw1);
                x = add_blk(x, sk, 1'b0);
            end
        end
        else
        begin
            if (STAGE == 0)
            begin
                sk = subkey(GROUPS, kw, in_item.tw0, in_item.tw1);
                x = add_blk(x, sk, 1'b1);
            end
            for (int d = 3; d >= 0; d--)
            begin
                x = dec_round(x, 3'(((GROUPS - 1 - STAGE) * 4 + d) % 8));
            end
            sk = subkey(GROUPS - 1 - STAGE, kw, in_item.tw0, in_item.tw1);
            x = add_blk(x, sk, 1'b1);
        end
        item_next.x = x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item = item_reg;
endmodule
`default_nettype wire

@@ src/threefish512_block_cipher_top.sv @@
// Top level of the Threefish-512 block cipher pipeline
// Usage: write the eight key words over APB at byte addresses 0x00..0x38
// (8-byte steps) while the pipeline is empty. Blocks enter on the input
// channel (valid/stall) with func, eight words and the tweak, one transfer
// per cycle while in_stall is low. The pipeline has ROUND_COUNT/4 stages
// of four rounds each; a transfer is registered in every stage before its
// result leaves; one result per cycle is sustained while out_stall is low.
// Each stage is one registered group of four rounds plus its subkey add.
// When out_stall is raised while the final stage is occupied, every stage
// holds; in_stall follows that condition, so nothing is lost or repeated.
// Reset clears all valid bits and the key registers to zero.
`default_nettype none
`include "threefish512_block_cipher_top_macros.svh"
module threefish512_block_cipher_top
    import tf512_pkg::*;
#(
    parameter int ROUND_COUNT = 72
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [63:0] in_word_0,
    input  wire logic [63:0] in_word_1,
    input  wire logic [63:0] in_word_2,
    input  wire logic [63:0] in_word_3,
    input  wire logic [63:0] in_word_4,
    input  wire logic [63:0] in_word_5,
    input  wire logic [63:0] in_word_6,
    input  wire logic [63:0] in_word_7,
    input  wire logic [63:0] tweak_lo,
    input  wire logic [63:0] tweak_hi,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      out_word_0,
    output logic [63:0]      out_word_1,
    output logic [63:0]      out_word_2,
    output logic [63:0]      out_word_3,
    output logic [63:0]      out_word_4,
    output logic [63:0]      out_word_5,
    output logic [63:0]      out_word_6,
    output logic [63:0]      out_word_7
);
    localparam int GROUPS = ROUND_COUNT / 4;

    word_t [7:0]  key_reg;
    word_t [8:0]  kw;
    logic         en;
    logic         v [GROUPS+1];
    item_t        it [GROUPS+1];

    assign pready = 1'b1;
    assign prdata = key_reg[paddr[5:3]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            key_reg[paddr[5:3]] <= pwdata;
        end
    end

    always_comb
    begin
        kw[8] = KEY_PARITY;
        for (int i = 0; i < 8; i++)
        begin
            kw[i] = key_reg[i];
            kw[8] = kw[8] ^ key_reg[i];
        end
    end

    assign en = !(v[GROUPS] && out_stall);
    assign in_stall = !en;

    assign v[0] = in_valid;
    assign it[0].func = func;
    assign it[0].x = {in_word_7, in_word_6, in_word_5, in_word_4,
                      in_word_3, in_word_2, in_word_1, in_word_0};
    assign it[0].tw0 = tweak_lo;
    assign it[0].tw1 = tweak_hi;

    for (genvar g = 0; g < GROUPS; g++)
    begin : g_stage
        tf512_stage #(.STAGE(g), .GROUPS(GROUPS)) u_stage (
            .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v[g]), .in_item(it[g]),
            .kw_flat(kw), .out_valid(v[g+1]), .out_item(it[g+1])
        );
    end

    assign out_valid = v[GROUPS];
    assign out_word_0 = it[GROUPS].x[0];
    assign out_word_1 = it[GROUPS].x[1];
    assign out_word_2 = it[GROUPS].x[2];
    assign out_word_3 = it[GROUPS].x[3];
    assign out_word_4 = it[GROUPS].x[4];
    assign out_word_5 = it[GROUPS].x[5];
    assign out_word_6 = it[GROUPS].x[6];
    assign out_word_7 = it[GROUPS].x[7];

    `TF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word_0))
    `TF_ASSERT_IMPL(a_stall, clk, rst_n, in_stall, out_valid && out_stall)
    `TF_ASSERT_NEXT(a_adv, clk, rst_n, !in_stall && v[GROUPS-1], out_valid)
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the Threefish-512 block cipher pipeline
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tf512_pkg::*;

    localparam int STAGES = 18;
    localparam int EFF_ROUNDS = 72;
    localparam int STALL_LIMIT = 20000;

    class cipher_scoreboard;
        word_t  key_words [8];
        block_t pending [$];
        int     mismatches;
        int     results_seen;
        int     encrypts;
        int     decrypts;
        int unsigned rot_by [8][4] = '{
            '{46, 36, 19, 37}, '{33, 27, 14, 42}, '{17, 49, 36, 39}, '{44, 9, 54, 56},
            '{39, 30, 34, 24}, '{13, 50, 10, 17}, '{25, 29, 39, 43}, '{8, 35, 56, 22}
        };

        function word_t rol(word_t v, int unsigned r);
            return (v << r) | (v >> (64 - r));
        endfunction

        function word_t ror(word_t v, int unsigned r);
            return (v >> r) | (v << (64 - r));
        endfunction

        function block_t schedule(int unsigned s, word_t t0, word_t t1);
            word_t  kw [9];
            word_t  tw [3];
            block_t sk;
            kw[8] = KEY_PARITY;
            for (int i = 0; i < 8; i++)
            begin
                kw[i] = key_words[i];
                kw[8] = kw[8] ^ key_words[i];
            end
            tw[0] = t0;
            tw[1] = t1;
            tw[2] = t0 ^ t1;
            for (int i = 0; i < 8; i++)
            begin
                sk[i] = kw[(s + i) % 9];
            end
            sk[5] = sk[5] + tw[s % 3];
            sk[6] = sk[6] + tw[(s + 1) % 3];
            sk[7] = sk[7] + word_t'(s);
            return sk;
        endfunction

        function block_t encipher(block_t b, word_t t0, word_t t1);
            block_t sk;
            block_t y;
            for (int d = 0; d < EFF_ROUNDS; d++)
            begin
                if (d % 4 == 0)
                begin
                    sk = schedule(d / 4, t0, t1);
                    for (int j = 0; j < 8; j++)
                        b[j] = b[j] + sk[j];
                end
                for (int j = 0; j < 4; j++)
                begin
                    b[2*j] = b[2*j] + b[2*j+1];
                    b[2*j+1] = rol(b[2*j+1], rot_by[d % 8][j]) ^ b[2*j];
                end
                y[0] = b[2]; y[1] = b[1]; y[2] = b[4]; y[3] = b[7];
                y[4] = b[6]; y[5] = b[5]; y[6] = b[0]; y[7] = b[3];
                b = y;
            end
            sk = schedule(EFF_ROUNDS / 4, t0, t1);
            for (int j = 0; j < 8; j++)
                b[j] = b[j] + sk[j];
            return b;
        endfunction

        function block_t decipher(block_t b, word_t t0, word_t t1);
            block_t sk;
            block_t y;
            sk = schedule(EFF_ROUNDS / 4, t0, t1);
            for (int j = 0; j < 8; j++)
                b[j] = b[j] - sk[j];
            for (int d = EFF_ROUNDS - 1; d >= 0; d--)
            begin
                y[2] = b[0]; y[1] = b[1]; y[4] = b[2]; y[7] = b[3];
                y[6] = b[4]; y[5] = b[5]; y[0] = b[6]; y[3] = b[7];
                b = y;
                for (int j = 0; j < 4; j++)
                begin
                    b[2*j+1] = ror(b[2*j+1] ^ b[2*j], rot_by[d % 8][j]);
                    b[2*j] = b[2*j] - b[2*j+1];
                end
                if (d % 4 == 0)
                begin
                    sk = schedule(d / 4, t0, t1);
                    for (int j = 0; j < 8; j++)
                        b[j] = b[j] - sk[j];
                end
            end
            return b;
        endfunction

        function void note_transfer(logic fn, block_t b, word_t t0, word_t t1);
            if (fn == FUNC_DECRYPT)
            begin
                decrypts++;
                pending.push_back(decipher(b, t0, t1));
            end
            else
            begin
                encrypts++;
                pending.push_back(encipher(b, t0, t1));
            end
        endfunction

        function void check_result(block_t got);
            block_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no transfer pending: %h", got);
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 8; i++)
            begin
                if (got[i] !== want[i])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("out_word_%0d: expected %h, got %h", i, want[i], got[i]);
                end
            end
        endfunction
    endclass

    cipher_scoreboard sb = new();

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        func = FUNC_ENCRYPT;
    block_t      in_blk = '0;
    word_t       tweak_lo = '0;
    word_t       tweak_hi = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    block_t      out_blk;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles = 0;
    int          key_settings = 0;

    always #5 clk = ~clk;

    threefish512_block_cipher_top u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .func(func),
        .in_word_0(in_blk[0]), .in_word_1(in_blk[1]), .in_word_2(in_blk[2]),
        .in_word_3(in_blk[3]), .in_word_4(in_blk[4]), .in_word_5(in_blk[5]),
        .in_word_6(in_blk[6]), .in_word_7(in_blk[7]),
        .tweak_lo(tweak_lo), .tweak_hi(tweak_hi),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_word_0(out_blk[0]), .out_word_1(out_blk[1]), .out_word_2(out_blk[2]),
        .out_word_3(out_blk[3]), .out_word_4(out_blk[4]), .out_word_5(out_blk[5]),
        .out_word_6(out_blk[6]), .out_word_7(out_blk[7])
    );

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_blk);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic write_key(int idx, word_t value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(8 * idx);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.key_words[idx] = value;
    endtask

    task automatic load_key(int kind);
        for (int i = 0; i < 8; i++)
            write_key(i, kind == 0 ? '0 : kind == 1 ? '1 : rand_word());
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        key_settings++;
    endtask

    task automatic send_block(logic fn, block_t b, word_t t0, word_t t1);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        in_blk <= b;
        tweak_lo <= t0;
        tweak_hi <= t1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transfer(fn, b, t0, t1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (STAGES + 4) @(posedge clk);
    endtask

    task automatic send_random(int count);
        block_t b;
        word_t  t0;
        word_t  t1;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 8; i++)
                b[i] = rand_word();
            t0 = ($urandom_range(9) == 0) ? '0 : rand_word();
            t1 = ($urandom_range(9) == 0) ? '1 : rand_word();
            if ($urandom_range(3) == 0)
                send_block(FUNC_DECRYPT, sb.encipher(b, t0, t1), t0, t1);
            else
                send_block(logic'($urandom_range(1)), b, t0, t1);
        end
    endtask

    task automatic send_directed();
        block_t b;
        for (int f = 0; f < 2; f++)
        begin
            send_block(logic'(f), '0, '0, '0);
            send_block(logic'(f), '1, '1, '1);
            send_block(logic'(f), '0, '1, '0);
            send_block(logic'(f), '1, '0, '1);
            send_block(logic'(f), {8{64'h8000000000000001}}, 64'h1, 64'h8000000000000000);
        end
        for (int n = 0; n < 6; n++)
        begin
            for (int i = 0; i < 8; i++)
                b[i] = rand_word();
            send_block(FUNC_DECRYPT, sb.encipher(b, 64'h5a5a, 64'ha5a5), 64'h5a5a, 64'ha5a5);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 6; ph++)
        begin
            load_key(ph < 2 ? ph : 2);
            send_idle_pct = (ph % 3 == 0) ? 15 : (ph % 3 == 1) ? 60 : 0;
            recv_idle_pct = (ph % 3 == 0) ? 60 : (ph % 3 == 1) ? 15 : 0;
            if (ph == 0)
                send_directed();
            send_random(150);
            drain();
        end
        $display("covered %0d encrypt and %0d decrypt transfers, %0d results, %0d keys",
                 sb.encrypts, sb.decrypts, sb.results_seen, key_settings);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+src
src/tf512_pkg.sv
src/tf512_stage.sv
src/threefish512_block_cipher_top.sv
dv/testbench.sv
